// ===== design/spq_pkg.sv =====
package spq_pkg;

    localparam int ID_W  = 8;
    localparam int PRI_W = 8;
    localparam int LEN_W = 3;

    // Request codes carried in the operation field.
    typedef enum logic [1:0] {
        OP_QUEUE = 2'd0,
        OP_STOP  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]       operation;
        logic [1:0]       player;
        logic [ID_W-1:0]  seq_id;
        logic [PRI_W-1:0] priority_req;
        logic [7:0]       fade_time;
    } t_cmd;

    typedef struct packed {
        logic             stop_current;
        logic             start_new;
        logic [ID_W-1:0]  start_seq;
        logic [PRI_W-1:0] start_priority;
        logic [7:0]       fade_out;
        logic [LEN_W-1:0] list_length;
    } t_rsp;

    // One stored list entry.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_entry;

    // Result of comparing one stored entry against the request.
    typedef struct packed {
        logic id_hit;
        logic pri_le;
    } t_cmp_res;

endpackage

// ===== design/spq_ifs.sv =====
interface spq_cmd_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/spq_mem.sv =====
module spq_mem #(
    parameter int DEPTH = 20,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  spq_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output spq_pkg::t_entry o_rdata
);
    import spq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/spq_cmp.sv =====
module spq_cmp (
    input  spq_pkg::t_entry                  i_entry,
    input  logic [spq_pkg::ID_W-1:0]         i_id,
    input  logic [spq_pkg::PRI_W-1:0]        i_pri,
    output spq_pkg::t_cmp_res                o_res
);
    import spq_pkg::*;

    // The new entry goes before the first stored entry of equal or lower priority.
    assign o_res.id_hit = (i_entry.id == i_id);
    assign o_res.pri_le = (i_entry.pri <= i_pri);

endmodule

// ===== design/sequence_priority_queue.sv =====
// Sorted per-player sequence list with start and stop decisions.
//
// Requests arrive on i_cmd (valid/ready); each transfer carries an operation
// (queue, stop or clear), a player index, a sequence id, a priority and a raw
// fade value. Every request produces exactly one response transfer on o_rsp:
// whether to stop the playing head, whether to start a sequence (id and
// priority), the fade value and the resulting list length.
//
// One request is handled at a time. A single compare unit walks the player's
// list one entry per cycle out of the entry memory, then the sequencer shifts
// entries one position at a time (read, write back), and a queued entry is
// written last. i_cmd.ready rises in the cycle after the response is loaded.
//
// Reset clears the per-player counts and drops any pending response; the
// entry memory is not cleared, since only slots below the count are read.
// A stalled response stays in the output register; the block takes one more
// request meanwhile and holds its response until the register is free.
module sequence_priority_queue #(
    parameter int PLAYERS    = 4,
    parameter int LIST_DEPTH = 5
) (
    input logic        i_clk,
    input logic        i_rst_n,
    spq_cmd_if.sink    i_cmd,
    spq_rsp_if.source  o_rsp
);
    import spq_pkg::*;

    localparam int ENTRIES = PLAYERS * LIST_DEPTH;
    localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW      = $clog2(LIST_DEPTH + 1);
    localparam int PW      = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MV_RD,
        S_MV_WR,
        S_INS,
        S_FIN
    } t_state;

    t_state r_state;

    // Request held for the whole operation.
    logic [1:0]       r_op;
    logic [PW-1:0]    r_pl;
    logic             r_pl_ok;
    logic [ID_W-1:0]  r_id;
    logic [PRI_W-1:0] r_pri;
    logic [7:0]       r_fade;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    r_cnt;

    // Scan pipeline and its findings.
    logic [CW-1:0]    r_idx;
    logic             r_cmp_vld;
    logic [CW-1:0]    r_cmp_idx;
    logic             r_hit;
    logic [CW-1:0]    r_hit_idx;
    logic             r_lo;
    logic [CW-1:0]    r_lo_idx;
    t_entry           r_second;

    // Shift sequencer.
    logic [CW-1:0]    r_dst;
    logic [CW-1:0]    r_end;
    logic             r_up;
    logic [CW-1:0]    r_pos;

    // Decision.
    logic             r_stop;
    logic             r_start;
    logic [ID_W-1:0]  r_sseq;
    logic [PRI_W-1:0] r_spri;
    logic [CW-1:0]    r_new_cnt;

    logic [CW-1:0]    r_cnt_tab [PLAYERS];

    logic             r_out_vld;
    t_rsp             r_out;

    // Memory and compare unit hookup.
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_entry           mem_wdata;
    logic [AW-1:0]    mem_raddr;
    t_entry           mem_rdata;
    t_cmp_res         cmp_res;

    logic             cmd_acc;
    logic             rsp_free;
    logic             scan_issue;
    logic [CW-1:0]    mv_src;
    logic [CW-1:0]    ins_pos;
    logic             ins_room;
    logic [CW-1:0]    ins_cnt;
    logic [CW-1:0]    ins_last;
    logic             pl_in_range;
    t_entry           new_entry;

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign rsp_free    = !r_out_vld || o_rsp.ready;
    assign scan_issue  = (r_idx < r_cnt);
    assign mv_src      = r_up ? (r_dst + ONE_C) : (r_dst - ONE_C);
    assign pl_in_range = (32'(i_cmd.data.player) < 32'(PLAYERS));

    // Insertion point: before the first entry of equal or lower priority,
    // otherwise at the tail. A full list with no such entry takes nothing.
    assign ins_pos  = r_lo ? r_lo_idx : r_cnt;
    assign ins_room = r_lo || (r_cnt < DEPTH_C);
    assign ins_cnt  = (r_cnt < DEPTH_C) ? (r_cnt + ONE_C) : r_cnt;
    assign ins_last = ins_cnt - ONE_C;

    assign new_entry.id  = r_id;
    assign new_entry.pri = r_pri;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_base + AW'(r_dst);
        mem_wdata = mem_rdata;
        mem_raddr = r_base;
        case (r_state)
            S_SCAN: begin
                mem_raddr = r_base + AW'(r_idx);
            end
            S_MV_RD: begin
                mem_raddr = r_base + AW'(mv_src);
            end
            S_MV_WR: begin
                mem_we = 1'b1;
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_base + AW'(r_pos);
                mem_wdata = new_entry;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    spq_mem #(
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    spq_cmp u_cmp (
        .i_entry (mem_rdata),
        .i_id    (r_id),
        .i_pri   (r_pri),
        .o_res   (cmp_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            for (int p = 0; p < PLAYERS; p++) begin
                r_cnt_tab[p] <= '0;
            end
        end else begin
            // The response register empties on its transfer and refills in S_FIN.
            if (r_state == S_FIN && rsp_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_op      <= i_cmd.data.operation;
                        r_pl      <= PW'(i_cmd.data.player);
                        r_pl_ok   <= pl_in_range;
                        r_id      <= i_cmd.data.seq_id;
                        r_pri     <= i_cmd.data.priority_req;
                        r_fade    <= i_cmd.data.fade_time;
                        r_base    <= AW'(32'(i_cmd.data.player) * LIST_DEPTH);
                        r_cnt     <= pl_in_range ? r_cnt_tab[PW'(i_cmd.data.player)] : '0;
                        r_idx     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_hit     <= 1'b0;
                        r_lo      <= 1'b0;
                        r_stop    <= 1'b0;
                        r_start   <= 1'b0;
                        r_sseq    <= '0;
                        r_spri    <= '0;
                        r_new_cnt <= '0;
                        r_state   <= pl_in_range ? S_SCAN : S_FIN;
                    end
                end

                S_SCAN: begin
                    if (scan_issue) begin
                        r_idx <= r_idx + ONE_C;
                    end
                    r_cmp_vld <= scan_issue;
                    r_cmp_idx <= r_idx;
                    if (r_cmp_vld) begin
                        if (cmp_res.id_hit && !r_hit) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_cmp_idx;
                        end
                        if (cmp_res.pri_le && !r_lo) begin
                            r_lo     <= 1'b1;
                            r_lo_idx <= r_cmp_idx;
                        end
                        // The entry behind the head becomes the head when the head is removed.
                        if (r_cmp_idx == ONE_C) begin
                            r_second <= mem_rdata;
                        end
                    end
                    if (!scan_issue && !r_cmp_vld) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    r_new_cnt <= r_cnt;
                    r_state   <= S_FIN;
                    case (r_op)
                        OP_QUEUE: begin
                            if (r_hit) begin
                                // Already listed: restart only when it is the head.
                                if (r_hit_idx == '0) begin
                                    r_start <= 1'b1;
                                    r_sseq  <= r_id;
                                    r_spri  <= r_pri;
                                end
                            end else if (ins_room) begin
                                r_new_cnt <= ins_cnt;
                                r_pos     <= ins_pos;
                                if (ins_pos == '0) begin
                                    r_start <= 1'b1;
                                    r_sseq  <= r_id;
                                    r_spri  <= r_pri;
                                end
                                if (ins_last > ins_pos) begin
                                    r_dst   <= ins_last;
                                    r_end   <= ins_pos + ONE_C;
                                    r_up    <= 1'b0;
                                    r_state <= S_MV_RD;
                                end else begin
                                    r_state <= S_INS;
                                end
                            end
                        end
                        OP_STOP: begin
                            if (r_hit) begin
                                r_new_cnt <= r_cnt - ONE_C;
                                if (r_hit_idx == '0) begin
                                    r_stop <= 1'b1;
                                    if (r_cnt > ONE_C) begin
                                        r_start <= 1'b1;
                                        r_sseq  <= r_second.id;
                                        r_spri  <= r_second.pri;
                                    end
                                end
                                if ((r_hit_idx + ONE_C) < r_cnt) begin
                                    r_dst   <= r_hit_idx;
                                    r_end   <= r_cnt - TWO_C;
                                    r_up    <= 1'b1;
                                    r_state <= S_MV_RD;
                                end
                            end else if (r_cnt == '0) begin
                                // Stop on an empty list still stops whatever plays.
                                r_stop <= 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            r_new_cnt <= '0;
                        end
                        default: begin
                            r_new_cnt <= r_cnt;
                        end
                    endcase
                end

                S_MV_RD: begin
                    r_state <= S_MV_WR;
                end

                S_MV_WR: begin
                    if (r_dst == r_end) begin
                        r_state <= r_up ? S_FIN : S_INS;
                    end else begin
                        r_dst   <= r_up ? (r_dst + ONE_C) : (r_dst - ONE_C);
                        r_state <= S_MV_RD;
                    end
                end

                S_INS: begin
                    r_state <= S_FIN;
                end

                S_FIN: begin
                    if (rsp_free) begin
                        r_out.stop_current   <= r_stop;
                        r_out.start_new      <= r_start;
                        r_out.start_seq      <= r_sseq;
                        r_out.start_priority <= r_spri;
                        r_out.fade_out       <= r_fade;
                        r_out.list_length    <= r_pl_ok ? LEN_W'(r_new_cnt) : '0;
                        if (r_pl_ok) begin
                            r_cnt_tab[r_pl] <= r_new_cnt;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

// ===== design/spq_chk.sv =====
module spq_chk #(
    parameter int LIST_DEPTH = 5
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cmd_valid,
    input logic          i_cmd_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input spq_pkg::t_rsp i_rsp_data
);
    import spq_pkg::*;

    // A stalled response keeps its valid and its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("response changed while stalled");

    // Reset leaves no response pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // A request transfer always makes the sequencer busy, so ready is low in the next cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("request taken while the previous one is in progress");

    // Without a start the start fields read zero.
    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.start_new |->
            i_rsp_data.start_seq == '0 && i_rsp_data.start_priority == '0)
        else $error("start fields set without a start");

    // The reported length never exceeds the list capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> 32'(i_rsp_data.list_length) <= 32'(LIST_DEPTH))
        else $error("list length beyond capacity");

endmodule

bind sequence_priority_queue spq_chk #(
    .LIST_DEPTH (LIST_DEPTH)
) u_spq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_valid (i_cmd.valid),
    .i_cmd_ready (i_cmd.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== bench/spq_checker.sv =====
module spq_checker #(
    parameter int PLAYERS    = 4,
    parameter int LIST_DEPTH = 5
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_cmd_if   i_cmd,
    spq_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // Shadow copy of every player's sorted list, head at index zero.
    t_entry play_lists [PLAYERS][LIST_DEPTH];
    int     list_fill  [PLAYERS];

    // Actions still owed by the block, oldest first.
    t_rsp   owed_actions [$];
    int     rsp_index;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        rsp_index    = 0;
    end

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        o_fail_count++;
        $display("%0t ns: response %0d: %s expected %0h got %0h",
                 $time, rsp_index, what, want, got);
    endtask

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            report_mismatch(what, want, got);
        end
    endtask

    function automatic int locate_id(int pl, int fill, logic [ID_W-1:0] id);
        int i;
        for (i = 0; i < fill; i++) begin
            if (play_lists[pl][i].id == id) begin
                return i;
            end
        end
        return fill;
    endfunction

    // Updates the shadow list of the addressed player and returns the stop
    // and start decisions, fade value and list length the request must produce.
    function automatic t_rsp apply_request(t_cmd req);
        t_rsp   act;
        t_entry fresh;
        int     pl;
        int     fill;
        int     pos;
        int     i;

        act        = '0;
        pl         = int'(req.player);
        fill       = list_fill[pl];
        fresh.id   = req.seq_id;
        fresh.pri  = req.priority_req;
        pos        = locate_id(pl, fill, req.seq_id);

        case (req.operation)
            OP_QUEUE: begin
                if (pos < fill) begin
                    // Already listed; only a head hit restarts it.
                    if (pos == 0) begin
                        act.start_new      = 1'b1;
                        act.start_seq      = req.seq_id;
                        act.start_priority = req.priority_req;
                    end
                end else begin
                    pos = fill;
                    for (i = 0; i < fill; i++) begin
                        if (play_lists[pl][i].pri <= req.priority_req) begin
                            pos = i;
                            break;
                        end
                    end
                    // A full list whose every entry outranks the request
                    // leaves pos at the depth, and the request is dropped.
                    if (pos < LIST_DEPTH) begin
                        if (fill < LIST_DEPTH) begin
                            fill++;
                        end
                        for (i = fill - 1; i > pos; i--) begin
                            play_lists[pl][i] = play_lists[pl][i-1];
                        end
                        play_lists[pl][pos] = fresh;
                        if (pos == 0) begin
                            act.start_new      = 1'b1;
                            act.start_seq      = req.seq_id;
                            act.start_priority = req.priority_req;
                        end
                    end
                end
            end
            OP_STOP: begin
                if (pos < fill) begin
                    for (i = pos; i + 1 < fill; i++) begin
                        play_lists[pl][i] = play_lists[pl][i+1];
                    end
                    fill--;
                end
                // The head went away, or the list was empty all along.
                if (pos == 0) begin
                    act.stop_current = 1'b1;
                    if (fill != 0) begin
                        act.start_new      = 1'b1;
                        act.start_seq      = play_lists[pl][0].id;
                        act.start_priority = play_lists[pl][0].pri;
                    end
                end
            end
            OP_CLEAR: begin
                fill = 0;
            end
            default: begin
            end
        endcase

        list_fill[pl]   = fill;
        act.fade_out    = req.fade_time;
        act.list_length = fill[LEN_W-1:0];
        return act;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            owed_actions.delete();
            for (int p = 0; p < PLAYERS; p++) begin
                list_fill[p] = 0;
            end
        end else begin
            // Retire first: a response always belongs to an earlier request.
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_actions.size() == 0) begin
                    report_mismatch("response with no request waiting", '0, '0);
                end else begin
                    want = owed_actions.pop_front();
                    check_field("stop_current", 8'(want.stop_current),
                                8'(i_rsp.data.stop_current));
                    check_field("start_new", 8'(want.start_new),
                                8'(i_rsp.data.start_new));
                    check_field("start_seq", want.start_seq, i_rsp.data.start_seq);
                    check_field("start_priority", want.start_priority,
                                i_rsp.data.start_priority);
                    check_field("fade_out", want.fade_out, i_rsp.data.fade_out);
                    check_field("list_length", 8'(want.list_length),
                                8'(i_rsp.data.list_length));
                end
                rsp_index++;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                owed_actions.push_back(apply_request(i_cmd.data));
            end
        end
        o_pending = owed_actions.size();
    end

endmodule

// ===== bench/tb_sequence_priority_queue.sv =====
// Top of the bench: clock, reset, request traffic and the final verdict.
// All response checking against expected values lives in spq_checker, which
// sits beside the block and watches both channels.
module tb_sequence_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int PLAYERS    = 4;
    localparam int LIST_DEPTH = 5;

    // The operation field has room for one code the block does not know.
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    // Roughly how many random requests follow the directed ones.
    localparam int RANDOM_REQUESTS = 1250;

    // The block can hold one finished response while it works on the next,
    // so this drain covers anything still in flight once the expectation
    // store runs empty.
    localparam int DRAIN_CYCLES = 48;

    bit   i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    // Receiver state: a running counter and the current stall pattern.
    int   rx_cycle;
    int   rx_mode;

    spq_cmd_if cmd_if ();
    spq_rsp_if rsp_if ();

    sequence_priority_queue #(
        .PLAYERS    (PLAYERS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    spq_checker #(
        .PLAYERS    (PLAYERS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns period. The clock is a bit, so no edge is seen at time zero.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop at 5 ms, far beyond the slowest legal run (every request
    // waiting out the longest sender gap, the full walk and a long
    // receiver stall).
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver drives ready at every falling edge. It rotates between
    // always ready, a fair coin, mostly stalled, and a fixed periodic rhythm,
    // so that stalls land on every stage of the block's internal walk and
    // some stretches run with no back-pressure at all.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 128 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= ((rx_cycle % 7) < 2);
        endcase
    end

    // Presents one request at the falling edge and holds it until the
    // block takes it. A following call keeps valid high, so back-to-back
    // requests form one burst without valid ever dropping in between.
    task automatic send_request(logic [1:0] op, logic [1:0] pl, logic [7:0] id,
                                logic [7:0] pri, logic [7:0] fade);
        @(negedge i_clk);
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= '{operation: op, player: pl, seq_id: id,
                          priority_req: pri, fade_time: fade};
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Drops valid for a number of cycles. The payload keeps changing so that
    // a block that looks at data without valid would be caught.
    task automatic pause_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            cmd_if.valid <= 1'b0;
            cmd_if.data  <= t_cmd'($urandom);
        end
    endtask

    initial begin
        int         sent;
        int         burst;
        logic [1:0] op;
        logic [1:0] pl;
        logic [7:0] id;
        logic [7:0] pri;

        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        rsp_if.ready = 1'b0;
        rx_cycle     = 0;
        rx_mode      = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk over player 0. A stop on an empty list still asks
        // for the head to be stopped.
        send_request(OP_STOP,  2'd0, 8'h12, 8'h34, 8'h01);
        send_request(OP_QUEUE, 2'd0, 8'h00, 8'h00, 8'h00);
        send_request(OP_QUEUE, 2'd0, 8'hFF, 8'hFF, 8'hFF);
        // Requeue of the head restarts it with the new priority; requeue of
        // an entry further down changes nothing.
        send_request(OP_QUEUE, 2'd0, 8'hFF, 8'h10, 8'h22);
        send_request(OP_QUEUE, 2'd0, 8'h00, 8'h7F, 8'h33);
        // Equal priorities: a newcomer goes ahead of entries it ties with.
        send_request(OP_QUEUE, 2'd0, 8'h55, 8'h80, 8'h44);
        send_request(OP_QUEUE, 2'd0, 8'hAA, 8'h80, 8'h55);
        send_request(OP_QUEUE, 2'd0, 8'h11, 8'h00, 8'h66);
        // The list is full now; this insert pushes the tail entry out.
        send_request(OP_QUEUE, 2'd0, 8'h22, 8'h00, 8'h77);
        // Stop of an absent id, then of the head, then of a middle entry.
        send_request(OP_STOP,  2'd0, 8'h99, 8'h00, 8'h88);
        send_request(OP_STOP,  2'd0, 8'hFF, 8'h00, 8'h99);
        send_request(OP_STOP,  2'd0, 8'h55, 8'hFF, 8'hAA);
        send_request(OP_UNDEFINED, 2'd0, 8'hAA, 8'h80, 8'hBB);
        send_request(OP_CLEAR, 2'd0, 8'h00, 8'h00, 8'hCC);

        // Player 1 fills up with middling priorities, then gets a request
        // that ranks below all of them and must be thrown away, then one
        // that ranks above all of them.
        for (int k = 1; k <= LIST_DEPTH; k++) begin
            send_request(OP_QUEUE, 2'd1, 8'(k), 8'h40, 8'(k));
        end
        send_request(OP_QUEUE, 2'd1, 8'h06, 8'h3F, 8'hDD);
        send_request(OP_QUEUE, 2'd1, 8'h07, 8'hC0, 8'hEE);
        send_request(OP_STOP,  2'd3, 8'h01, 8'h01, 8'hF0);
        send_request(OP_QUEUE, 2'd2, 8'h80, 8'h01, 8'h0F);
        send_request(OP_CLEAR, 2'd2, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_STOP,  2'd1, 8'h07, 8'h00, 8'h5A);

        // Random traffic. Ids come mostly from a small pool so that lists
        // fill up, requeues hit and stops find their entries; priorities
        // cluster on a few values so that ties are common. Clears are kept
        // rare or the lists would seldom reach full depth.
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(40, 120);
            end else begin
                burst = $urandom_range(1, 12);
            end
            repeat (burst) begin
                case ($urandom_range(0, 99)) inside
                    [0:59]:  op = OP_QUEUE;
                    [60:92]: op = OP_STOP;
                    [93:96]: op = OP_CLEAR;
                    default: op = OP_UNDEFINED;
                endcase
                pl = 2'($urandom_range(0, PLAYERS - 1));
                if ($urandom_range(0, 9) < 7) begin
                    id = 8'($urandom_range(0, 9));
                end else begin
                    id = 8'($urandom_range(0, 255));
                end
                case ($urandom_range(0, 3))
                    0:       pri = {2'($urandom_range(0, 3)), 6'd0};
                    1:       pri = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                    default: pri = 8'($urandom_range(0, 255));
                endcase
                send_request(op, pl, id, pri, 8'($urandom_range(0, 255)));
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 10));
            end
        end
        pause_sender(1);

        // Wait for every owed response, then give the block time to show a
        // stray one before judging.
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
